// ===== src/utf8_to_utf16_transcoder_macros.svh =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_macros
// Assertion macros shared by the transcoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define U8U16_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8u16 same-cycle check failed");

// next-cycle implication, disabled while in reset
`define U8U16_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8u16 next-cycle check failed");

`endif

// ===== src/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Constants and decode helpers for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam int unsigned MaxUnits = 3;

  localparam logic [15:0] Replacement = 16'hFFFD;
  localparam logic [15:0] SurrHiBase  = 16'hD800;
  localparam logic [15:0] SurrLoBase  = 16'hDC00;

  typedef logic [15:0] unit_t;
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  seq_len_t;

  // sequence length announced by a leader, zero for an invalid leader
  function automatic seq_len_t lead_len(input byte_t b);
    seq_len_t len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // a byte decoded on its own: ascii passes, anything else is replaced
  function automatic unit_t single_unit(input byte_t b);
    return b[7] ? Replacement : {8'h00, b};
  endfunction

  // two-byte sequence, continuation top bits ignored
  function automatic unit_t two_byte_unit(input byte_t b0, input byte_t b1);
    return {5'b00000, b0[4:0], b1[5:0]};
  endfunction

endpackage

`default_nettype wire

// ===== src/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streaming UTF-8 to UTF-16 transcoder, one text byte per item in.
// ----------------------------------------------------------------------------
// Input channel (s_*): one UTF-8 byte per item in s_tdata, s_tlast on the
// final byte of a text. Output channel (m_*): one UTF-16 code unit per item
// in m_tdata; m_tlast marks the final unit caused by an input byte and
// m_tuser[0] marks the final unit of the whole text.
// A byte is taken into an input register, decoded against the held bytes of
// an open sequence in one pass and the resulting units (up to three) land in
// an output buffer, whose front unit drives the output. Bytes that only extend
// an open sequence give no unit.
// Throughput: one byte accepted per cycle and one unit delivered per cycle
// while the receiver keeps m_tready high; a byte that yields two or three
// units (a surrogate pair, or the flush of a sequence cut short by the end
// of the text) holds the input while the output buffer drains.
// Reset (rst, synchronous) empties both registers and drops any open sequence.
// When the receiver stalls, the buffered unit holds and the input register
// fills, after which s_tready goes low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_utf16_transcoder_macros.svh"

module utf8_to_utf16_transcoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,   // in_last
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] code_unit
  output logic             m_tlast,   // run_last
  output logic [0:0]       m_tuser    // [0] text_end
);

  // input register
  logic                s1_valid;
  u8u16_pkg::byte_t    s1_byte;
  logic                s1_last;

  // open sequence state
  u8u16_pkg::byte_t    held_bytes [3];
  logic [1:0]          held_count;
  u8u16_pkg::seq_len_t expected_length;

  // output buffer, unit 0 is the one on the bus
  u8u16_pkg::unit_t    ob_unit [3];
  logic [1:0]          ob_cnt;
  logic                ob_end;

  // decode signals
  u8u16_pkg::seq_len_t lead_n;
  u8u16_pkg::seq_len_t len_eff;
  u8u16_pkg::seq_len_t n_bytes;
  u8u16_pkg::byte_t    b0, b1, b2, b3;
  logic [20:0]         cp;
  logic [20:0]         cp_off;
  logic                hold;
  logic                partial;
  u8u16_pkg::unit_t    dec_unit [3];
  logic [1:0]          dec_cnt;
  logic                load_ok;
  logic                ob_load;
  logic                s1_fire;
  logic                m_fire;

  // assemble the byte run: held bytes followed by the current byte
  always_comb begin
    lead_n  = u8u16_pkg::lead_len(s1_byte);
    n_bytes = {1'b0, held_count} + 3'd1;
    if (held_count == 2'd0) begin
      len_eff = (lead_n == 3'd0) ? 3'd1 : lead_n;
    end else begin
      len_eff = expected_length;
    end
    b0 = (held_count == 2'd0) ? s1_byte : held_bytes[0];
    b1 = (held_count == 2'd1) ? s1_byte : held_bytes[1];
    b2 = (held_count == 2'd2) ? s1_byte : held_bytes[2];
    b3 = s1_byte;
    partial = (n_bytes < len_eff);
    hold    = partial && !s1_last;
  end

  // code point of a complete sequence
  always_comb begin
    case (n_bytes)
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {5'd0, u8u16_pkg::single_unit(b0)};
    endcase
    cp_off = cp - 21'h10000;
  end

  // units produced by this byte
  always_comb begin
    dec_unit[0] = u8u16_pkg::Replacement;
    dec_unit[1] = u8u16_pkg::Replacement;
    dec_unit[2] = u8u16_pkg::Replacement;
    dec_cnt     = 2'd1;
    if (partial) begin
      // leader cut short by end of text, the rest restart as leaders
      case (n_bytes)
        3'd2: begin
          dec_unit[1] = u8u16_pkg::single_unit(b1);
          dec_cnt     = 2'd2;
        end
        3'd3: begin
          if (u8u16_pkg::lead_len(b1) == 3'd2) begin
            dec_unit[1] = u8u16_pkg::two_byte_unit(b1, b2);
            dec_cnt     = 2'd2;
          end else begin
            dec_unit[1] = u8u16_pkg::single_unit(b1);
            dec_unit[2] = u8u16_pkg::single_unit(b2);
            dec_cnt     = 2'd3;
          end
        end
        default: dec_cnt = 2'd1;
      endcase
    end else if (cp[20:16] != 5'd0) begin
      // surrogate pair
      dec_unit[0] = u8u16_pkg::SurrHiBase + {5'd0, cp_off[20:10]};
      dec_unit[1] = u8u16_pkg::SurrLoBase | {6'd0, cp_off[9:0]};
      dec_cnt     = 2'd2;
    end else begin
      dec_unit[0] = cp[15:0];
    end
  end

  // handshake control
  always_comb begin
    m_fire   = m_tvalid && m_tready;
    load_ok  = (ob_cnt == 2'd0) || (m_tready && ob_cnt == 2'd1);
    ob_load  = s1_valid && !hold && load_ok;
    s1_fire  = s1_valid && (hold || load_ok);
    s_tready = !s1_valid || s1_fire;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      s1_byte <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  // open sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      expected_length <= 3'd1;
    end else if (s1_fire) begin
      if (hold) begin
        held_count      <= n_bytes[1:0];
        expected_length <= len_eff;
      end else begin
        held_count      <= 2'd0;
        expected_length <= 3'd1;
      end
    end
    if (s1_fire && hold) begin
      held_bytes[held_count] <= s1_byte;
    end
  end

  // output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_cnt <= 2'd0;
    end else if (ob_load) begin
      ob_cnt <= dec_cnt;
    end else if (m_fire) begin
      ob_cnt <= ob_cnt - 2'd1;
    end
    if (ob_load) begin
      ob_unit[0] <= dec_unit[0];
      ob_unit[1] <= dec_unit[1];
      ob_unit[2] <= dec_unit[2];
      ob_end     <= s1_last;
    end else if (m_fire) begin
      ob_unit[0] <= ob_unit[1];
      ob_unit[1] <= ob_unit[2];
    end
  end

  // output ports
  always_comb begin
    m_tvalid   = (ob_cnt != 2'd0);
    m_tdata    = ob_unit[0];
    m_tlast    = (ob_cnt == 2'd1);
    m_tuser[0] = (ob_cnt == 2'd1) && ob_end;
  end

  // checks
  `U8U16_ASSERT_IMP(a_held_below_len, clk, rst, held_count != 2'd0, 3'(held_count) < expected_length)
  `U8U16_ASSERT_IMP(a_load_when_free, clk, rst, ob_load, (ob_cnt == 2'd0) || (m_fire && ob_cnt == 2'd1))
  `U8U16_ASSERT_NXT(a_drain_continues, clk, rst, m_fire && ob_cnt > 2'd1, m_tvalid)
  `U8U16_ASSERT_NXT(a_hold_no_output, clk, rst, s1_fire && hold && !m_tvalid, !m_tvalid)

endmodule

`default_nettype wire

// ===== bench/utf8_to_utf16_transcoder_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_tb
// Self-checking bench for the UTF-8 to UTF-16 stream transcoder.
// ----------------------------------------------------------------------------
// Text bytes are fed from a queue by a clocked driver and every accepted byte
// is run through a local transcoder model that queues the code units it
// should produce. A clocked monitor checks each unit delivered on the output
// stream against the oldest queued one. Texts are mostly well-formed UTF-8
// with random code points, mixed with stray bytes, bad leaders, loose
// continuation bytes and texts cut off inside a sequence. Both sides throttle
// at random in two phases, then a long output stall backs up the input.
// ----------------------------------------------------------------------------

module utf8_to_utf16_transcoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD  = 12;
  localparam int          PHASE_BYTES = 135;
  localparam int          LONG_HOLD   = 120;
  localparam int          DRAIN_WAIT  = 20;
  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [15:0] HIGH_SURR   = 16'hD800;
  localparam logic [15:0] LOW_SURR    = 16'hDC00;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  typedef struct packed {
    logic [15:0] value;
    logic        run_end;
    logic        text_end;
  } code_unit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;

  // bytes waiting to be sent and units waiting to be seen
  text_byte_t byte_fifo [$];
  code_unit_t unit_fifo [$];

  int bytes_queued = 0;
  int bytes_taken  = 0;
  int fails        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic in_took = 1'b0;

  // model state: bytes of the open sequence and its announced length
  logic [7:0] seq_bytes [3];
  int         seq_count = 0;
  int         seq_want  = 1;

  utf8_to_utf16_transcoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // length a leading byte announces, zero when it cannot lead
  function automatic int lead_length(input logic [7:0] b);
    int len;
    casez (b)
      8'b0???????: len = 1;
      8'b110?????: len = 2;
      8'b1110????: len = 3;
      8'b11110???: len = 4;
      default:     len = 0;
    endcase
    return len;
  endfunction

  // continuation byte, now and then with wrong top bits
  function automatic logic [7:0] cont_byte(input logic [5:0] bits);
    logic [1:0] top;
    top = ($urandom_range(9) == 0) ? 2'($urandom) : 2'b10;
    return {top, bits};
  endfunction

  // work out the units one accepted byte produces
  task automatic transcode_byte(input logic [7:0] b, input logic last);
    logic [7:0]  run [4];
    logic [15:0] units [$];
    logic [20:0] cp;
    logic [20:0] off;
    code_unit_t  item;
    int          n;
    int          pos;
    int          len;
    for (int k = 0; k < seq_count; k++) run[k] = seq_bytes[k];
    run[seq_count] = b;
    n = seq_count + 1;
    if (seq_count == 0) begin
      len = lead_length(b);
      seq_want = (len == 0) ? 1 : len;
    end
    // sequence still open: hold the byte
    if (!last && n < seq_want) begin
      seq_bytes[n - 1] = b;
      seq_count = n;
      return;
    end
    // decode the run, a cut-off leader restarts at the next byte
    pos = 0;
    while (pos < n) begin
      len = lead_length(run[pos]);
      if (len == 0 || pos + len > n) begin
        cp = {5'b0, REPLACEMENT};
        pos++;
      end else begin
        case (len)
          1: cp = {14'b0, run[pos][6:0]};
          2: cp = {10'b0, run[pos][4:0], run[pos + 1][5:0]};
          3: cp = {5'b0, run[pos][3:0], run[pos + 1][5:0], run[pos + 2][5:0]};
          default: cp = {run[pos][2:0], run[pos + 1][5:0], run[pos + 2][5:0],
                         run[pos + 3][5:0]};
        endcase
        pos += len;
      end
      if (cp < SUPP_BASE) begin
        units.push_back(cp[15:0]);
      end else begin
        off = cp - SUPP_BASE;
        units.push_back(HIGH_SURR + {5'b0, off[20:10]});
        units.push_back(LOW_SURR + {6'b0, off[9:0]});
      end
    end
    seq_count = 0;
    seq_want  = 1;
    foreach (units[k]) begin
      item.value    = units[k];
      item.run_end  = (k == units.size() - 1);
      item.text_end = last && (k == units.size() - 1);
      unit_fifo.push_back(item);
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    text_byte_t item;
    item.data = b;
    item.last = last;
    byte_fifo.push_back(item);
    bytes_queued++;
  endtask

  // one random text, mostly well-formed sequences; returns its byte count
  task automatic queue_text(output int nbytes);
    logic [7:0]  txt [$];
    logic [7:0]  enc [4];
    logic [20:0] cp;
    int          pieces;
    int          kind;
    int          len;
    int          keep;
    pieces = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        txt.push_back(8'($urandom));
      end else begin
        len = $urandom_range(1, 4);
        cp  = 21'($urandom);
        case (len)
          1: enc[0] = {1'b0, cp[6:0]};
          2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = cont_byte(cp[5:0]);
          end
          3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = cont_byte(cp[11:6]);
            enc[2] = cont_byte(cp[5:0]);
          end
          default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = cont_byte(cp[17:12]);
            enc[2] = cont_byte(cp[11:6]);
            enc[3] = cont_byte(cp[5:0]);
          end
        endcase
        keep = len;
        // broken sequence, more often when it closes the text
        if (len > 1 && (kind < 22 || (p == pieces - 1 && kind < 40)))
          keep = $urandom_range(1, len - 1);
        for (int k = 0; k < keep; k++) txt.push_back(enc[k]);
      end
    end
    foreach (txt[k]) queue_byte(txt[k], k == txt.size() - 1);
    nbytes = txt.size();
  endtask

  task automatic run_phase();
    int total;
    int got;
    total = 0;
    while (total < PHASE_BYTES) begin
      queue_text(got);
      total += got;
    end
    wait (bytes_taken == bytes_queued);
  endtask

  // sender: next byte once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_took) begin
      if (byte_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= byte_fifo[0].data;
        s_tlast  <= byte_fifo[0].last;
        void'(byte_fifo.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus an occasional long hold
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on accepted bytes, check delivered units
  always @(posedge clk) begin
    code_unit_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        bytes_taken++;
        transcode_byte(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (unit_fifo.size() == 0) begin
          $error("unexpected code unit %h", m_tdata);
          fails++;
        end else begin
          want = unit_fifo.pop_front();
          if (m_tdata !== want.value) begin
            $error("code_unit: expected %h, got %h", want.value, m_tdata);
            fails++;
          end
          if (m_tlast !== want.run_end) begin
            $error("run_last: expected %b, got %b", want.run_end, m_tlast);
            fails++;
          end
          if (m_tuser[0] !== want.text_end) begin
            $error("text_end: expected %b, got %b", want.text_end, m_tuser[0]);
            fails++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    send_idle_pct = 32;
    recv_idle_pct = 74;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // short text: ascii ends, widest two, three and four byte forms,
    // bad leaders, then a continuation with wrong top bits
    queue_byte(8'h00, 1'b0); queue_byte(8'h7F, 1'b0);
    queue_byte(8'hDF, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'hEF, 1'b0); queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'hF7, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'h80, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'hF8, 1'b0);
    queue_byte(8'hC3, 1'b0); queue_byte(8'h41, 1'b1);
    // surrogate code point passes through
    queue_byte(8'hED, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'h80, 1'b1);
    // text cut inside a four byte sequence, three replacements
    queue_byte(8'hF0, 1'b0); queue_byte(8'h90, 1'b0); queue_byte(8'h80, 1'b1);
    // cut leader followed by a valid two byte sequence
    queue_byte(8'hF0, 1'b0); queue_byte(8'hC3, 1'b0); queue_byte(8'hA9, 1'b1);
    // lone leader as a whole text
    queue_byte(8'hC3, 1'b1);
    wait (bytes_taken == bytes_queued);

    run_phase();
    send_idle_pct = 74;
    recv_idle_pct = 32;
    run_phase();
    // no throttling, long output stall while bytes keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    run_phase();

    wait (unit_fifo.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("utf8_to_utf16_transcoder: match");
    end else begin
      $display("utf8_to_utf16_transcoder: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(CLK_PERIOD * 200000);
    $display("utf8_to_utf16_transcoder: mismatch");
    $finish;
  end

endmodule
